@@ src/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types and constants for the LRU key/value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned KEY_IN_W   = 32;
  localparam int unsigned CFG_W      = 5;
  localparam int unsigned APB_W      = 32;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned REG_IDX_W  = PADDR_W - 2;

  localparam logic [CFG_W-1:0]     ACTIVE_RESET       = 5'd16;
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_ENTRIES = 1'b0;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOKUP = 3'b010,
    S_UPDATE = 3'b100
  } lkvc_state_e;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } lkvc_cmd_t;

endpackage

@@ src/lkvc_req_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_req_if
// Request channel: get or put with key and value.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] lookup_key;
  logic [31:0] write_value;

  modport source (output valid, output operation, output lookup_key,
                  output write_value, input ready);
  modport sink   (input valid, input operation, input lookup_key,
                  input write_value, output ready);
endinterface

@@ src/lkvc_rsp_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_rsp_if
// Response channel: hit flag and read value.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface

@@ src/lkvc_regs.sv @@
// ----------------------------------------------------------------------------
// lkvc_regs
// APB register slice holding active_entries and the clamped capacity.
// ----------------------------------------------------------------------------
module lkvc_regs
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned OCC_W   = $clog2(ENTRIES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  output logic [OCC_W-1:0]   capacity_o
);

  logic [CFG_W-1:0]     active_q, active_d;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [8:0]           active_ext;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    active_d = active_q;
    if (psel && penable && pwrite && pready && (reg_idx == REG_ACTIVE_ENTRIES)) begin
      active_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ACTIVE_RESET;
    end else begin
      active_q <= active_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_ACTIVE_ENTRIES) begin
      prdata = {{(APB_W-CFG_W){1'b0}}, active_q};
    end
  end

  // zero acts as one, anything above the store size acts as the store size
  assign active_ext = {{(9-CFG_W){1'b0}}, active_q};

  always_comb begin
    if (active_q == '0) begin
      capacity_o = OCC_W'(1);
    end else if (active_ext > 9'(ENTRIES)) begin
      capacity_o = OCC_W'(ENTRIES);
    end else begin
      capacity_o = OCC_W'(active_ext);
    end
  end

endmodule

@@ src/lkvc_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: accept, look up, commit, and output register valid.
// ----------------------------------------------------------------------------
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lkvc_cmd_t cmd_o
);

  lkvc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;
  logic        accept;

  assign out_load   = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) || out_load;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.capture = accept;
  assign cmd_o.lookup  = (state_q == S_LOOKUP);
  assign cmd_o.commit  = out_load;

  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_LOOKUP;
      end
      S_LOOKUP: begin
        state_d = S_UPDATE;
      end
      S_UPDATE: begin
        if (out_load) state_d = accept ? S_LOOKUP : S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ src/lkvc_datapath.sv @@
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry store, key compare, age ranks and result register.
// ----------------------------------------------------------------------------
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned OCC_W    = $clog2(ENTRIES + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkvc_cmd_t           cmd_i,
  input  logic                operation_i,
  input  logic [KEY_IN_W-1:0] lookup_key_i,
  input  logic [DATA_W-1:0]   write_value_i,
  input  logic [OCC_W-1:0]    capacity_i,
  output logic                hit_o,
  output logic [DATA_W-1:0]   read_value_o
);

  localparam int unsigned KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
  localparam int unsigned RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic              op_q;
  logic [KW-1:0]     key_q;
  logic [DATA_W-1:0] val_q;

  logic              valid_q [ENTRIES];
  logic [RW-1:0]     rank_q  [ENTRIES];
  logic [KW-1:0]     key_arr [ENTRIES];
  logic [DATA_W-1:0] val_arr [ENTRIES];
  logic [OCC_W-1:0]  occ_q;

  logic [ENTRIES-1:0] match_q, match_d;
  logic [ENTRIES-1:0] victim_q, victim_d;
  logic               full_q;

  logic [RW-1:0]      occ_last;
  logic               hit;
  logic [RW-1:0]      rank_hit;
  logic [DATA_W-1:0]  val_hit;
  logic               evict, insert, touch_en;
  logic [ENTRIES-1:0] sel;
  logic [RW-1:0]      rank_ref;

  logic              hit_q;
  logic [DATA_W-1:0] rdata_q;

  assign occ_last = RW'(occ_q - 1'b1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= operation_i;
      key_q <= lookup_key_i[KW-1:0];
      val_q <= write_value_i;
    end
  end

  // compare stage
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i]  = valid_q[i] && (key_arr[i] == key_q);
      victim_d[i] = valid_q[i] && (rank_q[i] == occ_last);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      match_q  <= match_d;
      victim_q <= victim_d;
      full_q   <= (occ_q >= capacity_i);
    end
  end

  // commit stage: at most one entry matches, so an OR collects its fields
  always_comb begin
    rank_hit = '0;
    val_hit  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        rank_hit = rank_hit | rank_q[i];
        val_hit  = val_hit | val_arr[i];
      end
    end
  end

  assign hit      = |match_q;
  assign evict    = !hit && (op_q == OP_PUT) && full_q;
  assign insert   = !hit && (op_q == OP_PUT) && !full_q;
  assign touch_en = hit || (op_q == OP_PUT);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit) begin
        sel[i] = match_q[i];
      end else if (evict) begin
        sel[i] = victim_q[i];
      end else begin
        sel[i] = (OCC_W'(i) == occ_q);
      end
    end
  end

  always_comb begin
    if (hit) begin
      rank_ref = rank_hit;
    end else if (evict) begin
      rank_ref = occ_last;
    end else begin
      rank_ref = RW'(occ_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
      occ_q <= '0;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (touch_en) begin
          if (sel[i]) begin
            rank_q[i] <= '0;
          end else if (valid_q[i] && (rank_q[i] < rank_ref)) begin
            rank_q[i] <= rank_q[i] + 1'b1;
          end
        end
        if (insert && sel[i]) valid_q[i] <= 1'b1;
      end
      if (insert) occ_q <= occ_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (sel[i] && (op_q == OP_PUT)) val_arr[i] <= val_q;
        if (sel[i] && (evict || insert)) key_arr[i] <= key_q;
      end
      hit_q   <= hit;
      rdata_q <= (hit && (op_q == OP_GET)) ? val_hit : '0;
    end
  end

  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;

endmodule

@@ src/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+--------------------------------------------
//  req     | in  | valid / ready | operation, lookup_key, write_value
//  rsp     | out | valid / ready | hit, read_value
//  apb     | in  | psel/penable  | paddr, pwdata, pwrite -> prdata, pready
//
//  Each transfer has a compare cycle over all keys, then a
//  commit cycle that updates ranks and loads the result register.
//  A new request is taken in the commit cycle of the one before it.
//  Reset clears valid bits, ranks and occupancy at once; no clearing pass.
//  A stalled response holds the commit cycle once the result register is full.
// ----------------------------------------------------------------------------
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  lkvc_req_if.sink           req,
  lkvc_rsp_if.source         rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);

  lkvc_cmd_t        cmd;
  logic [OCC_W-1:0] capacity;

  lkvc_regs #(
    .ENTRIES (ENTRIES),
    .OCC_W   (OCC_W)
  ) u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .cmd_o       (cmd)
  );

  lkvc_datapath #(
    .ENTRIES  (ENTRIES),
    .KEY_BITS (KEY_BITS),
    .OCC_W    (OCC_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (req.operation),
    .lookup_key_i  (req.lookup_key),
    .write_value_i (req.write_value),
    .capacity_i    (capacity),
    .hit_o         (rsp.hit),
    .read_value_o  (rsp.read_value)
  );

endmodule

@@ src/lkvc_checker.sv @@
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks on the cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
  import lkvc_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic              rsp_hit,
  input logic [DATA_W-1:0] rsp_read_value,
  input logic              pready
);

  logic [1:0] pend_q, pend_d;

  always_comb begin
    pend_d = pend_q;
    if (req_valid && req_ready) pend_d = pend_d + 2'd1;
    if (rsp_valid && rsp_ready) pend_d = pend_d - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two requests outstanding");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (pend_q != 2'd0))
    else $error("response without a request");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_hit) |-> (rsp_read_value == '0))
    else $error("miss returned non-zero value");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_hit) && $stable(rsp_read_value)))
    else $error("stalled response changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready dropped");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_read_value (rsp.read_value),
  .pready         (pready)
);

@@ tb/sv/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key/value cache. Get and put requests are
// driven on the request channel while an in-bench model of the store (keys,
// values, age ranks, occupancy, capacity register) predicts each reply. The
// reply channel is checked in order, field by field. The capacity register is
// rewritten over the APB port between phases with the store idle, covering
// zero, one, the maximum, values above it and values below the current fill.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
  import lkvc_pkg::*;

  localparam int CACHE_ENTRIES = 16;
  localparam int CYCLE_LIMIT   = 300000;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
  } cache_reply_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_W-1:0]   pwdata;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_key_value_cache #(
    .ENTRIES  (CACHE_ENTRIES),
    .KEY_BITS (32)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // store model
  bit          cache_valid [CACHE_ENTRIES];
  logic [31:0] cache_key   [CACHE_ENTRIES];
  logic [31:0] cache_value [CACHE_ENTRIES];
  int          cache_rank  [CACHE_ENTRIES];
  int          cache_fill;
  logic [CFG_W-1:0] cache_capacity;

  cache_reply_t pending_replies [$];
  int           mismatch_count;
  int           cycle_count;
  bit           idle_on;
  int           rsp_hold_request;
  logic [31:0]  key_pool [24];
  int           pool_size;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic void note_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %0d: %s expected %h got %h at %0t",
               mismatch_count, what, exp_v, act_v, $realtime);
  endfunction

  function automatic void promote_entry(int slot);
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (cache_valid[i] && i != slot && cache_rank[i] < cache_rank[slot])
        cache_rank[i]++;
    cache_rank[slot] = 0;
  endfunction

  function automatic cache_reply_t predict_access(logic op, logic [31:0] k, logic [31:0] v);
    cache_reply_t reply;
    int slot;
    int victim;
    int limit;
    reply  = '0;
    slot   = -1;
    victim = -1;
    for (int i = 0; i < CACHE_ENTRIES; i++)
      if (slot < 0 && cache_valid[i] && cache_key[i] == k)
        slot = i;
    if (slot >= 0) begin
      reply.hit = 1'b1;
      if (op == OP_PUT)
        cache_value[slot] = v;
      else
        reply.read_value = cache_value[slot];
      promote_entry(slot);
      return reply;
    end
    if (op == OP_GET)
      return reply;
    limit = (cache_capacity == 0) ? 1 :
            (cache_capacity > CACHE_ENTRIES) ? CACHE_ENTRIES : int'(cache_capacity);
    if (cache_fill >= limit) begin
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (cache_valid[i] && (victim < 0 || cache_rank[i] > cache_rank[victim]))
          victim = i;
      cache_key[victim]   = k;
      cache_value[victim] = v;
      promote_entry(victim);
    end else begin
      for (int i = CACHE_ENTRIES - 1; i >= 0; i--)
        if (!cache_valid[i])
          slot = i;
      for (int i = 0; i < CACHE_ENTRIES; i++)
        if (cache_valid[i])
          cache_rank[i]++;
      cache_valid[slot] = 1'b1;
      cache_key[slot]   = k;
      cache_value[slot] = v;
      cache_rank[slot]  = 0;
      cache_fill++;
    end
    return reply;
  endfunction

  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        note_mismatch("unexpected reply, read_value", 32'h0, rsp_if.read_value);
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.hit !== want.hit)
          note_mismatch("hit", 32'(want.hit), 32'(rsp_if.hit));
        if (rsp_if.read_value !== want.read_value)
          note_mismatch("read_value", want.read_value, rsp_if.read_value);
      end
    end
  end

  initial begin : reply_sink
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left  = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rsp_hold_request > 0) begin
        hold_left        = rsp_hold_request;
        rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 15);
      end
    end
  end

  task automatic send_request(input logic op, input logic [31:0] k, input logic [31:0] v);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.lookup_key  <= k;
    req_if.write_value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    pending_replies.push_back(predict_access(op, k, v));
  endtask

  task automatic stop_requests();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
  endtask

  task automatic wait_for_replies();
    while (pending_replies.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write one register, then read the capacity register back
  task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    logic [31:0] want;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_ACTIVE_ENTRIES)
      cache_capacity = data[CFG_W-1:0];
    want = 32'(cache_capacity);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {REG_ACTIVE_ENTRIES, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want)
      note_mismatch("capacity register read", want, prdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [31:0] data);
    stop_requests();
    wait_for_replies();
    write_register(REG_ACTIVE_ENTRIES, data);
  endtask

  task automatic test_register_access();
    write_register(REG_SPARE, 32'h0000_0003);
    write_register(REG_ACTIVE_ENTRIES, 32'(ACTIVE_RESET));
    write_register(REG_SPARE, 32'hFFFF_FFFF);
  endtask

  task automatic test_get_put_basics();
    send_request(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
    send_request(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    send_request(OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
    send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(OP_GET, 32'h8000_0001, 32'h5A5A_5A5A);
  endtask

  task automatic test_eviction_order();
    set_capacity(32'd2);
    send_request(OP_PUT, 32'h0000_0001, 32'h1111_1111);
    send_request(OP_PUT, 32'h0000_0002, 32'h2222_2222);
    send_request(OP_GET, 32'h0000_0001, 32'h0);
    send_request(OP_PUT, 32'h0000_0003, 32'h3333_3333);
    send_request(OP_GET, 32'h0000_0002, 32'h0);
    send_request(OP_GET, 32'h0000_0001, 32'h0);
    // zero capacity behaves as one entry
    set_capacity(32'd0);
    send_request(OP_PUT, 32'h0000_0010, 32'h0000_0010);
    send_request(OP_PUT, 32'h0000_0011, 32'h0000_0011);
    send_request(OP_GET, 32'h0000_0010, 32'h0);
    send_request(OP_GET, 32'h0000_0011, 32'h0);
  endtask

  task automatic refill_key_pool(input int size);
    pool_size = size;
    foreach (key_pool[i])
      key_pool[i] = $urandom();
  endtask

  task automatic send_random_request();
    logic [31:0] k;
    if ($urandom_range(0, 99) < 85)
      k = key_pool[$urandom_range(0, pool_size - 1)];
    else
      k = $urandom();
    send_request(logic'($urandom_range(0, 1)), k, $urandom());
  endtask

  task automatic test_backpressure();
    set_capacity(32'd8);
    refill_key_pool(10);
    idle_on = 1'b0;
    rsp_hold_request = 80;
    repeat (24) send_random_request();
    stop_requests();
    wait_for_replies();
    idle_on = 1'b1;
  endtask

  task automatic run_random_phase(input logic [31:0] cap_word, input int count);
    int limit;
    set_capacity(cap_word);
    limit = (cache_capacity == 0) ? 1 :
            (cache_capacity > CACHE_ENTRIES) ? CACHE_ENTRIES : int'(cache_capacity);
    refill_key_pool($urandom_range(1, (limit + 6 > 24) ? 24 : limit + 6));
    repeat (count) send_random_request();
  endtask

  initial begin
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = OP_GET;
    req_if.lookup_key  = '0;
    req_if.write_value = '0;
    rsp_hold_request   = 0;
    idle_on            = 1'b1;
    mismatch_count     = 0;
    cycle_count        = 0;
    cache_fill         = 0;
    cache_capacity     = ACTIVE_RESET;
    foreach (cache_valid[i]) begin
      cache_valid[i] = 1'b0;
      cache_rank[i]  = 0;
    end
    pool_size = 1;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_register_access();
    test_get_put_basics();
    test_eviction_order();
    test_backpressure();
    run_random_phase(32'd16, 55);
    run_random_phase(32'hFFFF_FFFF, 55);
    run_random_phase(32'd3, 55);
    run_random_phase(32'd1, 50);
    run_random_phase(32'd0, 45);
    run_random_phase(32'hFFFF_FFE8, 55);
    run_random_phase(32'd17, 55);
    run_random_phase(32'd5, 55);
    idle_on = 1'b0;
    run_random_phase(32'd16, 60);

    stop_requests();
    wait_for_replies();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_replies.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
